[rtl/plids_pkg.sv]
// Package for the positional list unit: word types, codes and the float compare.
// Used by plids_cell and by the top level; depends on nothing.
package plids_pkg;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_SEARCH = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  position;
        logic [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [4:0] found_position;
        logic [4:0] count;
    } t_out_word;

    // Per-cycle command broadcast to every cell of the row.
    typedef struct packed {
        logic        ins_en;
        logic        del_en;
        logic        cmp_en;
        logic [4:0]  slot;
        logic [31:0] value;
    } t_cell_ctl;

    function automatic logic is_nan(input logic [31:0] x);
        is_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    // IEEE equality: signed zeros match, a NaN never does.
    function automatic logic ieee_eq(input logic [31:0] a, input logic [31:0] b);
        if (is_nan(a) || is_nan(b)) begin
            ieee_eq = 1'b0;
        end else if (((a | b) & 32'h7FFF_FFFF) == 32'd0) begin
            ieee_eq = 1'b1;
        end else begin
            ieee_eq = (a == b);
        end
    endfunction

endpackage

[rtl/plids_cell.sv]
// One list slot: holds an entry, shifts it to or from its neighbors and flags a match.
// Depends on plids_pkg.
module plids_cell
    import plids_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic        i_clk,
    input  t_cell_ctl   i_ctl,
    input  logic [31:0] i_left,
    input  logic [31:0] i_right,
    output logic [31:0] o_value,
    output logic        o_match
);

    logic [31:0] r_value;
    logic        r_match;
    logic [31:0] n_value;
    logic [31:0] slot_ext;

    assign slot_ext = {27'd0, i_ctl.slot};

    // Insert opens a gap at the slot; delete closes it.
    always_comb begin
        n_value = r_value;
        if (i_ctl.ins_en) begin
            if (32'(IDX) == slot_ext) begin
                n_value = i_ctl.value;
            end else if (32'(IDX) > slot_ext) begin
                n_value = i_left;
            end
        end else if (i_ctl.del_en) begin
            if (32'(IDX) >= slot_ext) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_ctl.cmp_en) begin
            r_match <= ieee_eq(r_value, i_ctl.value);
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

[rtl/positional_list_insert_delete_search_unit.sv]
// Positional float list: a row of CAPACITY cells with insert, delete and search.
// Insert, delete and rejected commands: result next cycle, next start at once.
// Search: all cells compare at once, then a scan steps one flag per cycle
// until a match or the list end; busy is high until the result is out.
// Synchronous active-low reset empties the list; the receiver takes every result.
module positional_list_insert_delete_search_unit
    import plids_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_in,
    output logic      o_done,
    output t_out_word o_out
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]     r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_k, n_k;
    logic           r_done, n_done;
    t_out_word      r_out, n_out;
    t_cell_ctl      ctl;

    logic [31:0]    cell_val [CAPACITY];
    logic [CAPACITY-1:0] match;

    logic           accept;
    logic [31:0]    cnt_ext, pos_ext;

    assign accept  = start && (r_state == S_IDLE);
    assign cnt_ext = 32'(r_count);
    assign pos_ext = {27'd0, i_in.position};

    // Row of cells, each wired to its neighbors.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [31:0] left_v, right_v;
        if (g == 0) begin : g_first
            assign left_v = i_in.value;
        end else begin : g_mid
            assign left_v = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_v = cell_val[g];
        end else begin : g_inner
            assign right_v = cell_val[g+1];
        end
        plids_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_left  (left_v),
            .i_right (right_v),
            .o_value (cell_val[g]),
            .o_match (match[g])
        );
    end

    // Command decode and search scan.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_k     = r_k;
        n_done  = 1'b0;
        n_out   = r_out;
        ctl.ins_en = 1'b0;
        ctl.del_en = 1'b0;
        ctl.cmp_en = 1'b0;
        ctl.slot   = i_in.position - 5'd1;
        ctl.value  = i_in.value;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out.found          = 1'b0;
                    n_out.found_position = 5'd0;
                    n_out.status         = STATUS_OK;
                    case (i_in.func)
                        FUNC_INSERT: begin
                            if (cnt_ext >= 32'(CAPACITY)) begin
                                n_out.status = STATUS_FULL;
                            end else if (pos_ext == 32'd0 || pos_ext > cnt_ext + 32'd1) begin
                                n_out.status = STATUS_BAD;
                            end else begin
                                ctl.ins_en = 1'b1;
                                n_count    = r_count + CW'(1);
                            end
                            n_done = 1'b1;
                        end
                        FUNC_DELETE: begin
                            if (pos_ext == 32'd0 || pos_ext > cnt_ext) begin
                                n_out.status = STATUS_BAD;
                            end else begin
                                ctl.del_en = 1'b1;
                                n_count    = r_count - CW'(1);
                            end
                            n_done = 1'b1;
                        end
                        FUNC_SEARCH: begin
                            ctl.cmp_en = 1'b1;
                            n_k        = '0;
                            n_state    = S_SCAN;
                        end
                        default: begin
                            n_out.status = STATUS_BAD;
                            n_done       = 1'b1;
                        end
                    endcase
                    n_out.count = 5'(n_count);
                end
            end
            S_SCAN: begin
                if (r_k >= r_count) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (match[r_k[IW-1:0]]) begin
                    n_out.found          = 1'b1;
                    n_out.found_position = 5'(32'(r_k) + 32'd1);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_k   <= n_k;
        r_out <= n_out;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

[dv/positional_list_insert_delete_search_unit_tb.sv]
// Testbench for the positional float list: directed and random insert, delete and search
// words checked against a predictor of the list kept here. Depends on plids_pkg and the RTL.
module positional_list_insert_delete_search_unit_tb;
    import plids_pkg::*;

    localparam int CAP = 16;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_word  i_in;
    logic      o_done;
    t_out_word o_out;

    positional_list_insert_delete_search_unit #(.CAPACITY(CAP)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in(i_in), .o_done(o_done), .o_out(o_out)
    );

    t_in_word  pending_words[$];
    t_out_word expected_results[$];
    logic [31:0] list_model[CAP];
    int unsigned list_len;
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned idle_pct;
    logic rst_done;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic is_nan_word(logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 0);
    endfunction

    function automatic logic float_match(logic [31:0] a, logic [31:0] b);
        if (is_nan_word(a) || is_nan_word(b)) return 1'b0;
        if (((a | b) & 32'h7FFF_FFFF) == 0) return 1'b1;
        return a == b;
    endfunction

    // Apply one command word to the list copy and return the answer it should give.
    function automatic t_out_word apply_list_op(t_in_word w);
        t_out_word r;
        r = '0;
        r.status = STATUS_OK;
        case (w.func)
            FUNC_INSERT: begin
                if (list_len >= CAP) begin
                    r.status = STATUS_FULL;
                end else if (w.position < 1 || w.position > list_len + 1) begin
                    r.status = STATUS_BAD;
                end else begin
                    for (int k = list_len; k >= w.position; k--) list_model[k] = list_model[k-1];
                    list_model[w.position-1] = w.value;
                    list_len++;
                end
            end
            FUNC_DELETE: begin
                if (list_len == 0 || w.position < 1 || w.position > list_len) begin
                    r.status = STATUS_BAD;
                end else begin
                    for (int k = w.position; k < list_len; k++) list_model[k-1] = list_model[k];
                    list_len--;
                end
            end
            FUNC_SEARCH: begin
                for (int k = 0; k < list_len; k++) begin
                    if (float_match(list_model[k], w.value)) begin
                        r.found = 1'b1;
                        r.found_position = 5'(k + 1);
                        break;
                    end
                end
            end
            default: r.status = STATUS_BAD;
        endcase
        r.count = list_len[4:0];
        return r;
    endfunction

    // Values rich in signed zeros, NaNs, infinities and repeats.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return {1'b0, 8'hFF, 23'(($urandom_range(0, 1) ? 1 : $urandom))} | 32'h1;
            3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 23'h0};
            4, 5: return 32'(32'h3F80_0000 + $urandom_range(0, 5));
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_word(logic [1:0] f, logic [4:0] p, logic [31:0] v);
        t_in_word w;
        w.func = f;
        w.position = p;
        w.value = v;
        pending_words.push_back(w);
    endtask

    // Driver: offers the oldest pending word, with random gaps between words.
    always @(posedge i_clk) begin
        if (!rst_done) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            expected_results.push_back(apply_list_op(i_in));
            void'(pending_words.pop_front());
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_in <= pending_words[0];
            end else begin
                start <= 1'b0;
            end
        end else if (!start && pending_words.size() > 0 &&
                     $urandom_range(0, 99) >= idle_pct) begin
            start <= 1'b1;
            i_in <= pending_words[0];
        end
    end

    // Monitor: every strobed word is checked against the oldest expectation.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (rst_done && o_done) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result word %h", o_out);
                fail_count = fail_count + 1;
            end else begin
                t_out_word e;
                e = expected_results.pop_front();
                if (o_out.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_out.status);
                    fail_count = fail_count + 1;
                end
                if (o_out.found !== e.found) begin
                    $error("found expected %0d actual %0d", e.found, o_out.found);
                    fail_count = fail_count + 1;
                end
                if (o_out.found_position !== e.found_position) begin
                    $error("found_position expected %0d actual %0d",
                           e.found_position, o_out.found_position);
                    fail_count = fail_count + 1;
                end
                if (o_out.count !== e.count) begin
                    $error("count expected %0d actual %0d", e.count, o_out.count);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned fill;
        int unsigned r;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_in = '0;
        rst_done = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        idle_pct = 0;
        list_len = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done <= 1'b1;

        // Directed: empty list, signed zeros, NaN, bad positions, full list, unused code.
        queue_word(FUNC_DELETE, 5'd1, 32'h0);
        queue_word(FUNC_SEARCH, 5'd0, 32'h0);
        queue_word(FUNC_INSERT, 5'd0, 32'h1);
        queue_word(FUNC_INSERT, 5'd2, 32'h1);
        queue_word(FUNC_INSERT, 5'd1, 32'h8000_0000);
        queue_word(FUNC_INSERT, 5'd2, 32'h7FC0_0000);
        queue_word(FUNC_SEARCH, 5'd31, 32'h0000_0000);
        queue_word(FUNC_SEARCH, 5'd0, 32'h7FC0_0000);
        queue_word(FUNC_INSERT, 5'd1, 32'hFFFF_FFFF);
        queue_word(FUNC_SEARCH, 5'd0, 32'hFFFF_FFFF);
        queue_word(FUNC_UNUSED, 5'd1, 32'h0);
        for (int k = 0; k < 14; k++) queue_word(FUNC_INSERT, 5'(k + 1), 32'(k * 3));
        queue_word(FUNC_INSERT, 5'd1, 32'h5);
        queue_word(FUNC_SEARCH, 5'd0, 32'h27);
        queue_word(FUNC_DELETE, 5'd0, 32'h0);
        queue_word(FUNC_DELETE, 5'd17, 32'h0);
        queue_word(FUNC_DELETE, 5'd16, 32'hAAAA_5555);
        for (int k = 0; k < 16; k++) queue_word(FUNC_DELETE, 5'd1, 32'h0);

        // Random phases: no gaps, 64% gaps, 27% gaps, then none again.
        for (int ph = 0; ph < 4; ph++) begin
            wait (pending_words.size() == 0 && expected_results.size() == 0);
            @(posedge i_clk);
            idle_pct = (ph == 1) ? 64 : (ph == 2) ? 27 : 0;
            fill = list_len;
            for (int n = 0; n < 176; n++) begin
                r = $urandom_range(0, 99);
                // Keep the predicted size loosely tracked to steer toward full and empty.
                if (r < 45) begin
                    queue_word(FUNC_INSERT, 5'($urandom_range(0, fill + 2)), pick_value());
                    if (fill < CAP) fill++;
                end else if (r < 70) begin
                    queue_word(FUNC_DELETE, 5'($urandom_range(0, fill + 1)), pick_value());
                    if (fill > 0) fill--;
                end else if (r < 97) begin
                    queue_word(FUNC_SEARCH, 5'($urandom), pick_value());
                end else begin
                    queue_word(2'($urandom_range(0, 3)), 5'($urandom), $urandom);
                end
            end
        end

        wait (pending_words.size() == 0 && expected_results.size() == 0);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
